// ----- hdl/qvr_pkg.sv -----
// Shared constants, types and register codes for the quaternion vector rotator.
`timescale 1ns / 1ps
package qvr_pkg;

	localparam int COORD_W   = 32;
	localparam int QUAT_W    = 16;
	localparam int TOL_W     = 10;
	localparam int CFG_IDX_W = 3;
	localparam int CFG_DATA_W = QUAT_W;
	// Rotation matrix coefficient, product and sum widths
	localparam int COEF_W = 2 * QUAT_W + 2;
	localparam int PROD_W = COEF_W + COORD_W;
	localparam int SUM_W  = PROD_W + 2;
	// Squared norm of the quaternion
	localparam int NORM_W = 2 * QUAT_W + 1;
	localparam int QDEPTH = 4;
	localparam int QPTR_W = $clog2(QDEPTH);
	localparam int DIV_STEPS = COORD_W;

	typedef logic signed [COORD_W-1:0] coord_t;
	typedef logic signed [QUAT_W-1:0]  quat_t;

	localparam quat_t QUAT_ONE = quat_t'(1) <<< (QUAT_W - 2);
	localparam logic [TOL_W-1:0] TOL_RESET = TOL_W'(16);

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_QUAT_W = 3'd0,
		REG_QUAT_X = 3'd1,
		REG_QUAT_Y = 3'd2,
		REG_QUAT_Z = 3'd3,
		REG_TOL    = 3'd4
	} qvr_reg_t;

	typedef struct packed {
		quat_t            w;
		quat_t            x;
		quat_t            y;
		quat_t            z;
		logic [TOL_W-1:0] tol;
	} qvr_cfg_t;

	// Item data carried alongside the arithmetic
	typedef struct packed {
		logic                   pass;
		logic                   degen;
		logic [NORM_W-1:0]      norm;
		logic [2:0][COORD_W-1:0] vec;
	} qvr_side_t;

	typedef struct packed {
		qvr_side_t                     side;
		logic [2:0][2:0][COEF_W-1:0]   coef;
	} qvr_entry_t;

endpackage

// ----- hdl/qvr_if.sv -----
// Valid/ready channel interfaces for input vectors and rotated results.
`timescale 1ns / 1ps
interface qvr_in_if import qvr_pkg::*; ();
	logic   valid;
	logic   ready;
	logic   kind;
	coord_t vec_x;
	coord_t vec_y;
	coord_t vec_z;

	modport source (output valid, kind, vec_x, vec_y, vec_z, input ready);
	modport sink (input valid, kind, vec_x, vec_y, vec_z, output ready);
endinterface

interface qvr_out_if import qvr_pkg::*; ();
	logic   valid;
	logic   ready;
	coord_t out_x;
	coord_t out_y;
	coord_t out_z;
	logic   clipped;
	logic   degenerate;

	modport source (output valid, out_x, out_y, out_z, clipped, degenerate, input ready);
	modport sink (input valid, out_x, out_y, out_z, clipped, degenerate, output ready);
endinterface

// ----- hdl/qvr_front.sv -----
// Front end: classifies an item and builds its unnormalised rotation matrix.
`timescale 1ns / 1ps
module qvr_front import qvr_pkg::*; (
	input  qvr_cfg_t   cfg,
	input  logic       kind,
	input  coord_t     vec_x,
	input  coord_t     vec_y,
	input  coord_t     vec_z,
	output qvr_entry_t entry
);

	logic signed [2*QUAT_W-1:0] ww, xx, yy, zz, xy, xz, yz, wx, wy, wz;
	logic signed [COEF_W-1:0]   wxk, wyk, wzk;
	logic [QUAT_W:0]            dw, dx, dy, dz;
	logic [QUAT_W:0]            tol_ext;
	logic                       pass;
	logic [NORM_W-1:0]          norm;

	function automatic logic [QUAT_W:0] mag_of(input logic signed [QUAT_W:0] a);
		return a[QUAT_W] ? (QUAT_W+1)'(-a) : (QUAT_W+1)'(a);
	endfunction

	function automatic logic signed [COEF_W-1:0] ce(input logic signed [2*QUAT_W-1:0] a);
		return COEF_W'(a);
	endfunction

	assign ww = cfg.w * cfg.w;
	assign xx = cfg.x * cfg.x;
	assign yy = cfg.y * cfg.y;
	assign zz = cfg.z * cfg.z;
	assign xy = cfg.x * cfg.y;
	assign xz = cfg.x * cfg.z;
	assign yz = cfg.y * cfg.z;
	assign wx = cfg.w * cfg.x;
	assign wy = cfg.w * cfg.y;
	assign wz = cfg.w * cfg.z;

	// Conjugate flips the sign of every w.u term
	assign wxk = kind ? -ce(wx) : ce(wx);
	assign wyk = kind ? -ce(wy) : ce(wy);
	assign wzk = kind ? -ce(wz) : ce(wz);

	assign norm = NORM_W'(ww) + NORM_W'(xx) + NORM_W'(yy) + NORM_W'(zz);

	assign dw      = mag_of((QUAT_W+1)'(cfg.w) - (QUAT_W+1)'(QUAT_ONE));
	assign dx      = mag_of((QUAT_W+1)'(cfg.x));
	assign dy      = mag_of((QUAT_W+1)'(cfg.y));
	assign dz      = mag_of((QUAT_W+1)'(cfg.z));
	assign tol_ext = (QUAT_W+1)'(cfg.tol);
	assign pass    = (dw < tol_ext) && (dx < tol_ext) && (dy < tol_ext) && (dz < tol_ext);

	always_comb begin
		entry.side.pass  = pass;
		entry.side.degen = !pass && (norm == '0);
		entry.side.norm  = norm;
		entry.side.vec   = {vec_z, vec_y, vec_x};
		entry.coef[0][0] = ce(ww) + ce(xx) - ce(yy) - ce(zz);
		entry.coef[1][1] = ce(ww) - ce(xx) + ce(yy) - ce(zz);
		entry.coef[2][2] = ce(ww) - ce(xx) - ce(yy) + ce(zz);
		entry.coef[0][1] = (ce(xy) - wzk) <<< 1;
		entry.coef[0][2] = (ce(xz) + wyk) <<< 1;
		entry.coef[1][0] = (ce(xy) + wzk) <<< 1;
		entry.coef[1][2] = (ce(yz) - wxk) <<< 1;
		entry.coef[2][0] = (ce(xz) - wyk) <<< 1;
		entry.coef[2][1] = (ce(yz) + wxk) <<< 1;
	end

endmodule

// ----- hdl/qvr_queue.sv -----
// Short queue between the front end and the arithmetic back end.
`timescale 1ns / 1ps
module qvr_queue import qvr_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       push,
	input  qvr_entry_t push_data,
	output logic       full,
	input  logic       pop,
	output logic       empty,
	output qvr_entry_t head
);

	qvr_entry_t        mem_q [QDEPTH];
	logic [QPTR_W-1:0] wr_q, rd_q;
	logic [QPTR_W:0]   cnt_q;
	logic              push_fire, pop_fire;

	assign full      = cnt_q == (QPTR_W+1)'(QDEPTH);
	assign empty     = cnt_q == '0;
	assign push_fire = push && !full;
	assign pop_fire  = pop && !empty;
	assign head      = mem_q[rd_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push_fire)
				wr_q <= wr_q + 1'b1;
			if (pop_fire)
				rd_q <= rd_q + 1'b1;
			if (push_fire && !pop_fire)
				cnt_q <= cnt_q + 1'b1;
			else if (pop_fire && !push_fire)
				cnt_q <= cnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (push_fire)
			mem_q[wr_q] <= push_data;
	end

endmodule

// ----- hdl/qvr_back.sv -----
// Back end: matrix product, rounding divide by the squared norm, saturation.
`timescale 1ns / 1ps
module qvr_back import qvr_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_pop,
	input  qvr_entry_t entry,
	qvr_out_if.source  res
);

	localparam coord_t COORD_MAX = {1'b0, {(COORD_W-1){1'b1}}};
	localparam coord_t COORD_MIN = {1'b1, {(COORD_W-1){1'b0}}};

	logic en;

	logic                     vld_s1, vld_s2, vld_s3, vld_s4;
	qvr_side_t                side_s1, side_s2, side_s3, side_s4;
	logic signed [PROD_W-1:0] prod_s1 [3][3];
	logic signed [SUM_W-1:0]  e_s2 [3];
	logic [2:0]               neg_s3, neg_s4;
	logic [SUM_W-1:0]         mag_s3 [3];
	logic [SUM_W-1:0]         mag_s4 [3];

	// Divider chain; index 0 is loaded from stage 4
	logic                 dv_vld_s5  [DIV_STEPS+1];
	qvr_side_t            dv_side_s5 [DIV_STEPS+1];
	logic [2:0]           dv_neg_s5  [DIV_STEPS+1];
	logic [2:0]           dv_sat_s5  [DIV_STEPS+1];
	logic [NORM_W-1:0]    dv_rem_s5  [DIV_STEPS+1][3];
	logic [COORD_W-1:0]   dv_lo_s5   [DIV_STEPS+1][3];

	logic [SUM_W-1:0]     thr_pos, thr_neg;

	logic                 out_vld_q;
	coord_t               out_q [3];
	logic                 clipped_q, degen_q;
	coord_t               res_val [3];

	assign en     = !out_vld_q || res.ready;
	assign in_pop = en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1    <= 1'b0;
			vld_s2    <= 1'b0;
			vld_s3    <= 1'b0;
			vld_s4    <= 1'b0;
			out_vld_q <= 1'b0;
		end else if (en) begin
			vld_s1    <= in_valid;
			vld_s2    <= vld_s1;
			vld_s3    <= vld_s2;
			vld_s4    <= vld_s3;
			out_vld_q <= dv_vld_s5[DIV_STEPS];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			side_s1 <= entry.side;
			side_s2 <= side_s1;
			side_s3 <= side_s2;
			side_s4 <= side_s3;
			for (int i = 0; i < 3; i++) begin
				for (int j = 0; j < 3; j++)
					prod_s1[i][j] <= $signed(entry.coef[i][j]) * $signed(entry.side.vec[j]);
				e_s2[i]   <= SUM_W'(prod_s1[i][0]) + SUM_W'(prod_s1[i][1])
					+ SUM_W'(prod_s1[i][2]);
				neg_s3[i] <= e_s2[i][SUM_W-1];
				mag_s3[i] <= e_s2[i][SUM_W-1] ? SUM_W'(-e_s2[i]) : SUM_W'(e_s2[i]);
				// Add half the divisor to round to nearest, ties away from zero
				mag_s4[i] <= mag_s3[i] + SUM_W'(side_s3.norm >> 1);
			end
			neg_s4 <= neg_s3;
		end
	end

	assign thr_pos = SUM_W'(side_s4.norm) << (COORD_W - 1);
	assign thr_neg = thr_pos + SUM_W'(side_s4.norm);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			dv_vld_s5[0] <= 1'b0;
		else if (en)
			dv_vld_s5[0] <= vld_s4;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			dv_side_s5[0] <= side_s4;
			dv_neg_s5[0]  <= neg_s4;
			for (int i = 0; i < 3; i++) begin
				dv_sat_s5[0][i] <= neg_s4[i] ? (mag_s4[i] >= thr_neg)
					: (mag_s4[i] >= thr_pos);
				dv_rem_s5[0][i] <= mag_s4[i][COORD_W +: NORM_W];
				dv_lo_s5[0][i]  <= mag_s4[i][COORD_W-1:0];
			end
		end
	end

	for (genvar k = 0; k < DIV_STEPS; k++) begin : g_step
		logic [NORM_W:0]    trial [3];
		logic [2:0]         qbit;
		logic [NORM_W-1:0]  rem_nx [3];

		always_comb begin
			for (int i = 0; i < 3; i++) begin
				trial[i]  = {dv_rem_s5[k][i], dv_lo_s5[k][i][COORD_W-1]};
				qbit[i]   = trial[i] >= {1'b0, dv_side_s5[k].norm};
				rem_nx[i] = qbit[i] ? NORM_W'(trial[i] - {1'b0, dv_side_s5[k].norm})
					: NORM_W'(trial[i]);
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n)
				dv_vld_s5[k+1] <= 1'b0;
			else if (en)
				dv_vld_s5[k+1] <= dv_vld_s5[k];
		end

		// Shift quotient bits in at the bottom as dividend bits leave the top
		always_ff @(posedge clk) begin
			if (en) begin
				dv_side_s5[k+1] <= dv_side_s5[k];
				dv_neg_s5[k+1]  <= dv_neg_s5[k];
				dv_sat_s5[k+1]  <= dv_sat_s5[k];
				for (int i = 0; i < 3; i++) begin
					dv_rem_s5[k+1][i] <= rem_nx[i];
					dv_lo_s5[k+1][i]  <= {dv_lo_s5[k][i][COORD_W-2:0], qbit[i]};
				end
			end
		end
	end

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			if (dv_side_s5[DIV_STEPS].pass || dv_side_s5[DIV_STEPS].degen)
				res_val[i] = coord_t'(dv_side_s5[DIV_STEPS].vec[i]);
			else if (dv_sat_s5[DIV_STEPS][i])
				res_val[i] = dv_neg_s5[DIV_STEPS][i] ? COORD_MIN : COORD_MAX;
			else if (dv_neg_s5[DIV_STEPS][i])
				res_val[i] = coord_t'(-dv_lo_s5[DIV_STEPS][i]);
			else
				res_val[i] = coord_t'(dv_lo_s5[DIV_STEPS][i]);
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			out_q     <= res_val;
			degen_q   <= dv_side_s5[DIV_STEPS].degen;
			clipped_q <= !dv_side_s5[DIV_STEPS].pass && !dv_side_s5[DIV_STEPS].degen
				&& (|dv_sat_s5[DIV_STEPS]);
		end
	end

	assign res.valid      = out_vld_q;
	assign res.out_x      = out_q[0];
	assign res.out_y      = out_q[1];
	assign res.out_z      = out_q[2];
	assign res.clipped    = clipped_q;
	assign res.degenerate = degen_q;

	a_flags_exclusive: assert property (@(posedge clk) disable iff (!arst_n)
		res.valid |-> !(res.clipped && res.degenerate))
		else $error("clipped and degenerate both set");

	a_pop_loads: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && en) |=> vld_s1)
		else $error("popped item did not enter the pipeline");

	a_stall_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(dv_vld_s5[DIV_STEPS] && !en) |=> dv_vld_s5[DIV_STEPS])
		else $error("divider output lost during stall");

endmodule

// ----- hdl/quaternion_vector_rotate.sv -----
// Top level: configuration registers, front end, queue and arithmetic back end.
//
//   channel   | dir | handshake     | payload
//   vec_in    | in  | valid/ready   | kind, vec_x, vec_y, vec_z
//   vec_out   | out | valid/ready   | out_x, out_y, out_z, clipped, degenerate
//   cfg       | in  | cfg_we        | cfg_index, cfg_data
//
// One vector per cycle sustained while vec_out takes results; the result is
// registered after the 32-step pipelined divider that applies the norm.
// arst_n clears the queue, pipeline valids and loads the identity quaternion.
// An output stall freezes the back end; the four-entry queue keeps vec_in
// ready until it fills.
`timescale 1ns / 1ps
module quaternion_vector_rotate import qvr_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	qvr_in_if.sink                vec_in,
	qvr_out_if.source             vec_out
);

	qvr_cfg_t   cfg_q;
	qvr_entry_t front_entry, head;
	logic       q_full, q_empty, q_pop;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.w   <= QUAT_ONE;
			cfg_q.x   <= '0;
			cfg_q.y   <= '0;
			cfg_q.z   <= '0;
			cfg_q.tol <= TOL_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_QUAT_W: cfg_q.w   <= quat_t'(cfg_data);
				REG_QUAT_X: cfg_q.x   <= quat_t'(cfg_data);
				REG_QUAT_Y: cfg_q.y   <= quat_t'(cfg_data);
				REG_QUAT_Z: cfg_q.z   <= quat_t'(cfg_data);
				REG_TOL:    cfg_q.tol <= cfg_data[TOL_W-1:0];
				default: ;
			endcase
		end
	end

	qvr_front u_front (
		.cfg   (cfg_q),
		.kind  (vec_in.kind),
		.vec_x (vec_in.vec_x),
		.vec_y (vec_in.vec_y),
		.vec_z (vec_in.vec_z),
		.entry (front_entry)
	);

	assign vec_in.ready = !q_full;

	qvr_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (vec_in.valid),
		.push_data (front_entry),
		.full      (q_full),
		.pop       (q_pop),
		.empty     (q_empty),
		.head      (head)
	);

	qvr_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (!q_empty),
		.in_pop   (q_pop),
		.entry    (head),
		.res      (vec_out)
	);

endmodule

// ----- tb/sv/qvr_rotate_checker.sv -----
// Checker that predicts and compares every rotated vector of the quaternion rotator.
`timescale 1ns / 1ps
module qvr_rotate_checker import qvr_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	qvr_in_if                     vec_in,
	qvr_out_if                    vec_out,
	output int                    failures,
	output int                    pending
);

	typedef logic signed [129:0] acc_t;

	typedef struct {
		coord_t x;
		coord_t y;
		coord_t z;
		logic   clipped;
		logic   degenerate;
	} rotated_t;

	quat_t            qw, qx, qy, qz;
	logic [TOL_W-1:0] tol;
	rotated_t         rotated_q[$];

	function automatic longint abs_diff(input longint a, input longint b);
		return (a >= b) ? a - b : b - a;
	endfunction

	// Round to nearest with ties away from zero, then clamp to the coordinate range
	function automatic coord_t divide_round_sat(input acc_t e, input longint n,
			inout logic clip);
		acc_t   mag;
		acc_t   quot;
		longint lim;
		lim  = (longint'(1) <<< (COORD_W - 1)) - 1;
		mag  = (e < 0) ? -e : e;
		quot = (mag + acc_t'(n >>> 1)) / acc_t'(n);
		if (e < 0) begin
			if (quot > acc_t'(lim + 1)) begin
				clip = 1'b1;
				return coord_t'(-(lim + 1));
			end
			return coord_t'(-quot);
		end
		if (quot > acc_t'(lim)) begin
			clip = 1'b1;
			return coord_t'(lim);
		end
		return coord_t'(quot);
	endfunction

	function automatic rotated_t rotate_vector(input logic kind, input coord_t vx,
			input coord_t vy, input coord_t vz);
		rotated_t r;
		longint   w, x, y, z, n, d, c, one;
		longint   v[3], u[3], cr[3];
		acc_t     e;
		logic     clip;
		w = qw; x = qx; y = qy; z = qz;
		v[0] = vx; v[1] = vy; v[2] = vz;
		one = QUAT_ONE;
		r.x = vx; r.y = vy; r.z = vz;
		r.clipped = 1'b0;
		r.degenerate = 1'b0;
		if (abs_diff(w, one) < tol && abs_diff(x, 0) < tol && abs_diff(y, 0) < tol &&
				abs_diff(z, 0) < tol)
			return r;
		n = w * w + x * x + y * y + z * z;
		if (n == 0) begin
			r.degenerate = 1'b1;
			return r;
		end
		// Conjugate for the reverse rotation
		if (kind) begin
			x = -x; y = -y; z = -z;
		end
		u[0] = x; u[1] = y; u[2] = z;
		d = x * v[0] + y * v[1] + z * v[2];
		c = w * w - (x * x + y * y + z * z);
		cr[0] = y * v[2] - z * v[1];
		cr[1] = z * v[0] - x * v[2];
		cr[2] = x * v[1] - y * v[0];
		clip = 1'b0;
		for (int i = 0; i < 3; i++) begin
			e = acc_t'(2 * d) * acc_t'(u[i]) + acc_t'(c) * acc_t'(v[i]) +
				acc_t'(2 * w) * acc_t'(cr[i]);
			v[i] = divide_round_sat(e, n, clip);
		end
		r.x = coord_t'(v[0]);
		r.y = coord_t'(v[1]);
		r.z = coord_t'(v[2]);
		r.clipped = clip;
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		rotated_t exp_r;
		if (!arst_n) begin
			qw <= QUAT_ONE;
			qx <= '0;
			qy <= '0;
			qz <= '0;
			tol <= TOL_RESET;
			rotated_q.delete();
			failures <= 0;
			pending <= 0;
		end else begin
			if (cfg_we) begin
				case (qvr_reg_t'(cfg_index))
					REG_QUAT_W: qw <= quat_t'(cfg_data);
					REG_QUAT_X: qx <= quat_t'(cfg_data);
					REG_QUAT_Y: qy <= quat_t'(cfg_data);
					REG_QUAT_Z: qz <= quat_t'(cfg_data);
					REG_TOL:    tol <= cfg_data[TOL_W-1:0];
					default: ;
				endcase
			end
			if (vec_in.valid && vec_in.ready)
				rotated_q.push_back(rotate_vector(vec_in.kind, vec_in.vec_x,
					vec_in.vec_y, vec_in.vec_z));
			if (vec_out.valid && vec_out.ready) begin
				if (rotated_q.size() == 0) begin
					$error("result transfer with no vector outstanding");
					failures <= failures + 1;
				end else begin
					exp_r = rotated_q.pop_front();
					if (vec_out.out_x !== exp_r.x || vec_out.out_y !== exp_r.y ||
							vec_out.out_z !== exp_r.z ||
							vec_out.clipped !== exp_r.clipped ||
							vec_out.degenerate !== exp_r.degenerate)
						failures <= failures + 1;
					if (vec_out.out_x !== exp_r.x)
						$error("out_x expected %0d got %0d", exp_r.x, vec_out.out_x);
					if (vec_out.out_y !== exp_r.y)
						$error("out_y expected %0d got %0d", exp_r.y, vec_out.out_y);
					if (vec_out.out_z !== exp_r.z)
						$error("out_z expected %0d got %0d", exp_r.z, vec_out.out_z);
					if (vec_out.clipped !== exp_r.clipped)
						$error("clipped expected %0d got %0d", exp_r.clipped,
							vec_out.clipped);
					if (vec_out.degenerate !== exp_r.degenerate)
						$error("degenerate expected %0d got %0d", exp_r.degenerate,
							vec_out.degenerate);
				end
			end
			pending <= rotated_q.size();
		end
	end

endmodule

// ----- tb/sv/quaternion_vector_rotate_tb.sv -----
// Testbench top: drives vectors and quaternion settings, gives the verdict.
`timescale 1ns / 1ps
module quaternion_vector_rotate_tb import qvr_pkg::*; ();

	localparam int CYCLE_LIMIT = 200000;
	localparam int DRAIN_CYCLES = 50;
	localparam coord_t CMAX = coord_t'(32'h7fff_ffff);
	localparam coord_t CMIN = coord_t'(32'h8000_0000);

	logic                  clk;
	logic                  arst_n;
	logic                  cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;
	logic                  calm;
	int                    failures;
	int                    pending;
	int                    cycles = 0;

	qvr_in_if  vec_in_ch ();
	qvr_out_if vec_out_ch ();

	quaternion_vector_rotate DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.vec_in    (vec_in_ch),
		.vec_out   (vec_out_ch)
	);

	qvr_rotate_checker checker_i (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.vec_in    (vec_in_ch),
		.vec_out   (vec_out_ch),
		.failures  (failures),
		.pending   (pending)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("CHECKS FAILED");
			$finish;
		end
	end

	// Result side: ready in random bursts, held high once the run goes calm
	initial begin
		vec_out_ch.ready <= 1'b0;
		@(posedge clk);
		forever begin
			vec_out_ch.ready <= 1'b1;
			if (calm)
				@(posedge clk);
			else begin
				repeat ($urandom_range(1, 12)) @(posedge clk);
				if (!calm) begin
					vec_out_ch.ready <= 1'b0;
					repeat ($urandom_range(1, 5)) @(posedge clk);
				end
			end
		end
	end

	task automatic send_vec(input logic k, input coord_t x, input coord_t y,
			input coord_t z);
		vec_in_ch.valid <= 1'b1;
		vec_in_ch.kind  <= k;
		vec_in_ch.vec_x <= x;
		vec_in_ch.vec_y <= y;
		vec_in_ch.vec_z <= z;
		do @(posedge clk); while (!vec_in_ch.ready);
		if (!calm && $urandom_range(0, 3) == 0) begin
			vec_in_ch.valid <= 1'b0;
			repeat ($urandom_range(1, 5)) @(posedge clk);
		end
	endtask

	task automatic write_reg(input qvr_reg_t idx, input logic [CFG_DATA_W-1:0] data);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		@(posedge clk);
	endtask

	// Wait for the pipeline to empty, then load a new quaternion and tolerance
	task automatic load_quat(input quat_t w, input quat_t x, input quat_t y, input quat_t z,
			input logic [CFG_DATA_W-1:0] tol);
		vec_in_ch.valid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		write_reg(REG_QUAT_W, w);
		write_reg(REG_QUAT_X, x);
		write_reg(REG_QUAT_Y, y);
		write_reg(REG_QUAT_Z, z);
		write_reg(REG_TOL, tol);
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	function automatic coord_t rand_coord();
		case ($urandom_range(0, 5))
			0: return CMAX;
			1: return CMIN;
			2: return coord_t'($urandom_range(0, 2097152)) - coord_t'(1048576);
			3: return coord_t'($urandom_range(0, 3)) - coord_t'(1);
			default: return coord_t'($urandom);
		endcase
	endfunction

	function automatic quat_t rand_quat_part(input int mode);
		case (mode)
			0: return quat_t'($urandom);
			1: return quat_t'($urandom_range(0, 32768)) - quat_t'(16384);
			2: return quat_t'($urandom_range(0, 6)) - quat_t'(3);
			default: return quat_t'($urandom_range(0, 40)) - quat_t'(20);
		endcase
	endfunction

	initial begin
		int    mode;
		quat_t qw;
		calm            = 1'b0;
		arst_n          = 1'b0;
		cfg_we          = 1'b0;
		cfg_index       = '0;
		cfg_data        = '0;
		vec_in_ch.valid = 1'b0;
		vec_in_ch.kind  = 1'b0;
		vec_in_ch.vec_x = '0;
		vec_in_ch.vec_y = '0;
		vec_in_ch.vec_z = '0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Identity after reset: pass-through
		send_vec(1'b0, CMAX, CMIN, '0);
		send_vec(1'b1, coord_t'(65536), coord_t'(-1), CMAX);
		// Zero tolerance never passes, so the identity goes through the arithmetic
		load_quat(QUAT_ONE, '0, '0, '0, '0);
		send_vec(1'b0, CMAX, CMIN, coord_t'(12345));
		send_vec(1'b1, CMIN, CMAX, coord_t'(-1));
		// Near identity, inside the tolerance
		load_quat(QUAT_ONE + quat_t'(5), quat_t'(-3), quat_t'(15), quat_t'(-15), 16'd16);
		send_vec(1'b0, coord_t'(777), CMIN, CMAX);
		send_vec(1'b1, coord_t'(-777), CMAX, CMIN);
		// Zero quaternion with the widest tolerance
		load_quat('0, '0, '0, '0, 16'hffff);
		send_vec(1'b0, CMAX, coord_t'(3), CMIN);
		send_vec(1'b1, coord_t'(-5), CMIN, CMAX);
		// Extreme register values
		load_quat(quat_t'(-32768), quat_t'(32767), quat_t'(-32768), quat_t'(32767), 16'd1023);
		send_vec(1'b0, CMAX, CMAX, CMAX);
		send_vec(1'b1, CMIN, CMIN, CMIN);
		send_vec(1'b0, CMIN, CMAX, '0);
		// Tiny norm, a quarter turn about z in which each negated CMIN overflows
		load_quat(quat_t'(1), '0, '0, quat_t'(1), 16'd0);
		send_vec(1'b0, CMAX, CMIN, coord_t'(2));
		send_vec(1'b1, CMIN, CMAX, coord_t'(-2));
		// Quarter turn about z
		load_quat(quat_t'(11585), '0, '0, quat_t'(11585), 16'd16);
		send_vec(1'b0, coord_t'(65536), '0, '0);
		send_vec(1'b1, coord_t'(65536), coord_t'(131072), coord_t'(-65536));
		send_vec(1'b0, CMAX, CMIN, CMAX);
		// Writes to unused indices are ignored
		load_quat(QUAT_ONE, '0, '0, '0, 16'd16);
		for (int i = 5; i < 8; i++) begin
			cfg_we    <= 1'b1;
			cfg_index <= CFG_IDX_W'(i);
			cfg_data  <= CFG_DATA_W'($urandom);
			@(posedge clk);
		end
		cfg_we <= 1'b0;
		send_vec(1'b0, coord_t'(100), coord_t'(-100), CMAX);

		for (int ph = 0; ph < 8; ph++) begin
			mode = $urandom_range(0, 3);
			qw = (mode == 3) ? QUAT_ONE + rand_quat_part(3) : rand_quat_part(mode);
			load_quat(qw, rand_quat_part(mode), rand_quat_part(mode), rand_quat_part(mode),
				($urandom_range(0, 2) == 0) ? CFG_DATA_W'($urandom) :
				CFG_DATA_W'($urandom_range(0, 24)));
			if (ph == 7)
				calm = 1'b1;
			repeat (160)
				send_vec(1'($urandom), rand_coord(), rand_coord(),
					($urandom_range(0, 4) == 0) ? '0 : rand_coord());
		end

		vec_in_ch.valid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (failures == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule
